### hw/rtl/scan_p2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_p2p_pkg: shared types and constants for the scan-to-pixel converter
// Widths, register codes, sine polynomial and fixed-point scaling constants.
// ----------------------------------------------------------------------------
package scan_p2p_pkg;

	// image and scan geometry
	localparam int IMG_SIDE   = 500;
	localparam int INDEX_BITS = 12;

	// field widths
	localparam int IDX_W    = 12;
	localparam int RANGE_W  = 16;
	localparam int ANGLE_W  = 16;
	localparam int PPM_W    = 10;
	localparam int SCALED_W = RANGE_W + PPM_W;
	localparam int TRIG_W   = 16;
	localparam int PIX_W    = $clog2(IMG_SIDE);

	// stream word widths, padded to whole bytes
	localparam int IN_DATA_W  = ((IDX_W + RANGE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * PIX_W + 7) / 8) * 8;

	// index bits that take part in the angle
	localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
		IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_START_ANGLE = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_RANGE   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_PIX_PER_M   = 3'd4;

	localparam logic [ANGLE_W-1:0] RST_START_ANGLE = 16'd0;
	localparam logic [ANGLE_W-1:0] RST_ANGLE_STEP  = 16'd182;
	localparam logic [RANGE_W-1:0] RST_MIN_RANGE   = 16'd120;
	localparam logic [RANGE_W-1:0] RST_MAX_RANGE   = 16'd3500;
	localparam logic [PPM_W-1:0]   RST_PIX_PER_M   = 10'd100;

	typedef struct packed {
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] angle_step;
		logic [RANGE_W-1:0] min_range_mm;
		logic [RANGE_W-1:0] max_range_mm;
		logic [PPM_W-1:0]   pixels_per_meter;
	} cfg_t;

	// quarter-wave sine polynomial, Q14 angle in, Q15 out
	localparam logic [15:0] SIN_A   = 16'd51472;
	localparam logic [14:0] SIN_B   = 15'd21024;
	localparam logic [11:0] SIN_C   = 12'd2320;
	localparam logic [14:0] QUARTER = 15'd16384;
	localparam logic [14:0] SIN_MAX = 15'd32767;

	// pipeline depth per unit
	localparam int FRONT_LAT = 2;
	localparam int SINE_LAT  = 4;
	localparam int PROJ_LAT  = 4;
	localparam int PIPE_LAT  = FRONT_LAT + SINE_LAT + PROJ_LAT;

	// projection: coord = (CENTER*D + scaled*trig) / D, D = 2^15 * 1000
	localparam longint RANGE_DIV  = 64'd32768000;
	localparam int     DIV_SHIFT  = 15;
	localparam longint DIV_REM    = 64'd1000;
	localparam int     PROD_W     = SCALED_W + TRIG_W + 1;
	localparam int     NUM_W      = PROD_W + $clog2(IMG_SIDE);
	localparam int     N1_W       = $clog2(IMG_SIDE * 1000);
	localparam int     RECIP_SH   = N1_W + 10;
	localparam int     RECIP_W    = N1_W + 1;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((64'd1 << RECIP_SH) + DIV_REM - 64'd1) / DIV_REM);

	localparam logic signed [NUM_W-1:0] CENTER_NUM = NUM_W'((IMG_SIDE / 2) * RANGE_DIV);
	localparam logic signed [NUM_W-1:0] NUM_LO     = NUM_W'(-RANGE_DIV);
	localparam logic signed [NUM_W-1:0] NUM_HI     = NUM_W'(IMG_SIDE * RANGE_DIV);

endpackage

### hw/rtl/scan_p2p_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_p2p_front: beam angle, scaled range and range window
// Two stages: index and range products, then the start angle offset.
// ----------------------------------------------------------------------------
module scan_p2p_front (
	input  logic                                 clk,
	input  logic                                 en,
	input  scan_p2p_pkg::cfg_t                   cfg,
	input  logic [scan_p2p_pkg::IDX_W-1:0]       sample_index,
	input  logic [scan_p2p_pkg::RANGE_W-1:0]     range_mm,
	output logic [scan_p2p_pkg::ANGLE_W-1:0]     angle_s2,
	output logic [scan_p2p_pkg::SCALED_W-1:0]    scaled_s2,
	output logic                                 keep_s2
);
	import scan_p2p_pkg::*;

	logic [IDX_W-1:0]         idx_m;
	logic [IDX_W+ANGLE_W-1:0] step_full;
	logic [SCALED_W-1:0]      scaled;
	logic                     keep;

	logic [ANGLE_W-1:0]  step_s1;
	logic [SCALED_W-1:0] scaled_s1;
	logic                keep_s1;

	// stage 1: products and range window
	always_comb begin
		idx_m     = sample_index & IDX_MASK;
		step_full = idx_m * cfg.angle_step;
		scaled    = range_mm * cfg.pixels_per_meter;
		keep      = (range_mm >= cfg.min_range_mm) && (range_mm <= cfg.max_range_mm);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1   <= step_full[ANGLE_W-1:0];
			scaled_s1 <= scaled;
			keep_s1   <= keep;
		end
	end

	// stage 2: add start angle, wraps mod one turn
	always_ff @(posedge clk) begin
		if (en) begin
			angle_s2  <= cfg.start_angle + step_s1;
			scaled_s2 <= scaled_s1;
			keep_s2   <= keep_s1;
		end
	end

endmodule

### hw/rtl/scan_p2p_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_p2p_sine: pipelined Q1.15 sine of a 16-bit binary angle
// Quadrant fold, then the quarter-wave polynomial, one multiply per stage.
// ----------------------------------------------------------------------------
module scan_p2p_sine (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic [scan_p2p_pkg::ANGLE_W-1:0]         angle,
	output logic signed [scan_p2p_pkg::TRIG_W-1:0]   trig_s4
);
	import scan_p2p_pkg::*;

	logic [14:0] r_fold;
	logic [29:0] sq;
	logic [26:0] cz;
	logic [14:0] v;
	logic [29:0] vz;
	logic [15:0] p;
	logic [30:0] pr;
	logic [16:0] s;
	logic [14:0] sat;
	logic [15:0] mag;

	logic [14:0] r_s1, z2_s1;
	logic        neg_s1;
	logic [14:0] r_s2, z2_s2, v_s2;
	logic        neg_s2;
	logic [14:0] r_s3;
	logic [15:0] p_s3;
	logic        neg_s3;

	// stage 1: fold into a quarter turn, z2 = r*r >> 14
	always_comb begin
		r_fold = angle[14] ? (QUARTER - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
		sq     = r_fold * r_fold;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= r_fold;
			z2_s1  <= sq[28:14];
			neg_s1 <= angle[15];
		end
	end

	// stage 2: v = B - (C*z2 >> 14)
	always_comb begin
		cz = SIN_C * z2_s1;
		v  = SIN_B - {2'b00, cz[26:14]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2   <= r_s1;
			z2_s2  <= z2_s1;
			v_s2   <= v;
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: p = A - (v*z2 >> 14)
	always_comb begin
		vz = v_s2 * z2_s2;
		p  = SIN_A - vz[29:14];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3   <= r_s2;
			p_s3   <= p;
			neg_s3 <= neg_s2;
		end
	end

	// stage 4: s = p*r >> 14, saturate, apply half-turn sign
	always_comb begin
		pr  = p_s3 * r_s3;
		s   = pr[30:14];
		sat = (s > {2'b00, SIN_MAX}) ? SIN_MAX : s[14:0];
		mag = {1'b0, sat};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s4 <= neg_s3 ? -$signed(mag) : $signed(mag);
		end
	end

endmodule

### hw/rtl/scan_p2p_proj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_p2p_proj: one image axis from scaled range and Q1.15 trig value
// Multiply, add center offset, window check, divide by reciprocal multiply.
// ----------------------------------------------------------------------------
module scan_p2p_proj (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic [scan_p2p_pkg::SCALED_W-1:0]        scaled,
	input  logic signed [scan_p2p_pkg::TRIG_W-1:0]   trig,
	output logic [scan_p2p_pkg::PIX_W-1:0]           coord_s4,
	output logic                                     ok_s4
);
	import scan_p2p_pkg::*;

	logic signed [PROD_W-1:0] prod;
	logic signed [NUM_W-1:0]  num;
	logic                     ok;
	logic [N1_W-1:0]          n1;
	logic [N1_W+RECIP_W-1:0]  qm;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [NUM_W-1:0]  num_s2;
	logic                     ok_s3;
	logic [N1_W-1:0]          n1_s3;

	// stage 1: signed range times trig
	assign prod = $signed({1'b0, scaled}) * trig;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
		end
	end

	// stage 2: add center times divisor
	assign num = {{(NUM_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1} + CENTER_NUM;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= num;
		end
	end

	// stage 3: inside image after truncation toward zero; negatives map to 0
	always_comb begin
		ok = (num_s2 > NUM_LO) && (num_s2 < NUM_HI);
		n1 = num_s2[NUM_W-1] ? '0 : num_s2[DIV_SHIFT +: N1_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3 <= ok;
			n1_s3 <= n1;
		end
	end

	// stage 4: n1 / 1000 by reciprocal, exact over the checked range
	assign qm = n1_s3 * RECIP_M;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4    <= ok_s3;
			coord_s4 <= qm[RECIP_SH +: PIX_W];
		end
	end

endmodule

### hw/rtl/scan_polar_to_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_polar_to_pixel: laser range sample to image pixel with mark flag
// Path: front, sine and projection units from input word to output word.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits, and input ready is low only then.
// Reset: arst_n clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module scan_polar_to_pixel (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// sample_index [11:0], range_mm [27:12]
	input  logic [scan_p2p_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// pixel_x [8:0], pixel_y [17:9]
	output logic [scan_p2p_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// mark [0]
	output logic                                    m_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	input  logic                                    cfg_wr_en,
	input  logic [scan_p2p_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [scan_p2p_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import scan_p2p_pkg::*;

	cfg_t cfg_q;
	logic en;

	logic                       vld_s [1:PIPE_LAT];
	logic                       keep_s [FRONT_LAT+1:PIPE_LAT];
	logic [SCALED_W-1:0]        scaled_s [FRONT_LAT+1:FRONT_LAT+SINE_LAT];

	logic [ANGLE_W-1:0]         angle_s2;
	logic [ANGLE_W-1:0]         cos_angle;
	logic [SCALED_W-1:0]        scaled_s2;
	logic                       keep_s2;
	logic signed [TRIG_W-1:0]   cos_s6, sin_s6;
	logic [PIX_W-1:0]           x_s10, y_s10;
	logic                       okx_s10, oky_s10;
	logic                       mark;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_angle      <= RST_START_ANGLE;
			cfg_q.angle_step       <= RST_ANGLE_STEP;
			cfg_q.min_range_mm     <= RST_MIN_RANGE;
			cfg_q.max_range_mm     <= RST_MAX_RANGE;
			cfg_q.pixels_per_meter <= RST_PIX_PER_M;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_START_ANGLE: cfg_q.start_angle      <= cfg_wdata;
				REG_ANGLE_STEP:  cfg_q.angle_step       <= cfg_wdata;
				REG_MIN_RANGE:   cfg_q.min_range_mm     <= cfg_wdata;
				REG_MAX_RANGE:   cfg_q.max_range_mm     <= cfg_wdata;
				REG_PIX_PER_M:   cfg_q.pixels_per_meter <= cfg_wdata[PPM_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless the output word is stuck
	assign en            = !vld_s[PIPE_LAT] || m_axis_tready;
	assign s_axis_tready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PIPE_LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= PIPE_LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// side data alongside the sine and projection stages
	always_ff @(posedge clk) begin
		if (en) begin
			keep_s[FRONT_LAT+1]   <= keep_s2;
			for (int i = FRONT_LAT + 2; i <= PIPE_LAT; i++) keep_s[i] <= keep_s[i-1];
			scaled_s[FRONT_LAT+1] <= scaled_s2;
			for (int i = FRONT_LAT + 2; i <= FRONT_LAT + SINE_LAT; i++)
				scaled_s[i] <= scaled_s[i-1];
		end
	end

	scan_p2p_front u_front (
		.clk          (clk),
		.en           (en),
		.cfg          (cfg_q),
		.sample_index (s_axis_tdata[IDX_W-1:0]),
		.range_mm     (s_axis_tdata[IDX_W +: RANGE_W]),
		.angle_s2     (angle_s2),
		.scaled_s2    (scaled_s2),
		.keep_s2      (keep_s2)
	);

	// cosine is sine a quarter turn ahead
	assign cos_angle = {angle_s2[15:14] + 2'b01, angle_s2[13:0]};

	scan_p2p_sine u_cos (
		.clk     (clk),
		.en      (en),
		.angle   (cos_angle),
		.trig_s4 (cos_s6)
	);

	scan_p2p_sine u_sin (
		.clk     (clk),
		.en      (en),
		.angle   (angle_s2),
		.trig_s4 (sin_s6)
	);

	scan_p2p_proj u_proj_x (
		.clk      (clk),
		.en       (en),
		.scaled   (scaled_s[FRONT_LAT+SINE_LAT]),
		.trig     (cos_s6),
		.coord_s4 (x_s10),
		.ok_s4    (okx_s10)
	);

	scan_p2p_proj u_proj_y (
		.clk      (clk),
		.en       (en),
		.scaled   (scaled_s[FRONT_LAT+SINE_LAT]),
		.trig     (sin_s6),
		.coord_s4 (y_s10),
		.ok_s4    (oky_s10)
	);

	// output word, coordinates zeroed when not marked
	assign mark          = keep_s[PIPE_LAT] && okx_s10 && oky_s10;
	assign m_axis_tvalid = vld_s[PIPE_LAT];
	assign m_axis_tuser  = mark;
	assign m_axis_tdata  = mark ? OUT_DATA_W'({y_s10, x_s10}) : '0;

endmodule

### hw/rtl/scan_p2p_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_p2p_chk: port-level checks for the scan-to-pixel converter
// Watches stream ports: contract-breaking output words, needless input stalls.
// ----------------------------------------------------------------------------
module scan_p2p_chk (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [scan_p2p_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                    s_axis_tvalid,
	input  logic                                    s_axis_tready,
	input  logic [scan_p2p_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                    m_axis_tuser,
	input  logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready
);
	import scan_p2p_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// unmarked words carry zero coordinates
	a_unmarked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("unmarked word has nonzero coordinates");

	// marked pixels lie inside the image
	a_marked_inside: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		(m_axis_tdata[PIX_W-1:0] < PIX_W'(IMG_SIDE)) &&
		(m_axis_tdata[2*PIX_W-1:PIX_W] < PIX_W'(IMG_SIDE)))
		else $error("marked pixel outside image");

	// input side only stalls while an output word is pending
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// input payload is not checked here beyond being sampled
	logic unused_in;
	assign unused_in = ^{s_axis_tdata, s_axis_tvalid};

endmodule

bind scan_polar_to_pixel scan_p2p_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

### tb/scan_polar_to_pixel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_polar_to_pixel_tb: self-checking bench for the scan-to-pixel converter
// Streams range samples into the block under several register settings. Each
// accepted sample is projected by a local fixed-point model. The expected
// pixel words are kept in order and compared field by field with every word
// the block emits. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module scan_polar_to_pixel_tb;
	import scan_p2p_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 11;
	localparam int LIMIT_CYCLES = 200000;
	localparam int MAX_PRINTS   = 40;
	localparam int IDLE_PCT     = 33;
	// no register lives at this index; writes there must be ignored
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd6;

	typedef struct packed {
		logic [IDX_W-1:0]   sample_index;
		logic [RANGE_W-1:0] range_mm;
	} sample_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic             mark;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	// sample_index [11:0], range_mm [27:12]
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// pixel_x [8:0], pixel_y [17:9]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// mark [0]
	logic                  m_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	cfg_t    scan_cfg;
	sample_t samples_to_send[$];
	pixel_t  pixels_due[$];
	sample_t sample_on_bus;
	int      send_idle_pct = IDLE_PCT;
	int      sink_idle_pct = IDLE_PCT;
	int      mismatches = 0;

	scan_polar_to_pixel uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	// first-quadrant sine, Q14 angle in, Q15 out
	function automatic int unsigned quarter_wave(input int unsigned r);
		int unsigned z2, u, v, w, p, s;
		z2 = (r * r) >> 14;
		u  = (SIN_C * z2) >> 14;
		v  = SIN_B - u;
		w  = (v * z2) >> 14;
		p  = SIN_A - w;
		s  = (p * r) >> 14;
		if (s > SIN_MAX)
			s = SIN_MAX;
		return s;
	endfunction

	function automatic int sine_q15(input logic [ANGLE_W-1:0] a);
		logic [1:0]  quadrant;
		logic [13:0] r;
		int          s;
		quadrant = a[15:14];
		r        = a[13:0];
		if (quadrant[0])
			s = int'(quarter_wave(QUARTER - r));
		else
			s = int'(quarter_wave(r));
		return quadrant[1] ? -s : s;
	endfunction

	// center plus scaled offset, divided exactly and truncated toward zero
	function automatic longint coord_of(input longint scaled, input int trig);
		return (longint'(IMG_SIDE / 2) * RANGE_DIV + scaled * longint'(trig)) / RANGE_DIV;
	endfunction

	function automatic pixel_t project_sample(input sample_t smp);
		pixel_t             px;
		logic [ANGLE_W-1:0] beam;
		logic [IDX_W-1:0]   idx;
		longint             scaled, x, y;
		px   = '0;
		idx  = smp.sample_index & IDX_MASK;
		beam = scan_cfg.start_angle + idx * scan_cfg.angle_step;
		if (smp.range_mm < scan_cfg.min_range_mm || smp.range_mm > scan_cfg.max_range_mm)
			return px;
		scaled = longint'(smp.range_mm) * longint'(scan_cfg.pixels_per_meter);
		x = coord_of(scaled, sine_q15(beam + ANGLE_W'(QUARTER)));
		y = coord_of(scaled, sine_q15(beam));
		if (x >= 0 && x < IMG_SIDE && y >= 0 && y < IMG_SIDE) begin
			px.pixel_x = PIX_W'(x);
			px.pixel_y = PIX_W'(y);
			px.mark    = 1'b1;
		end
		return px;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTS)
			$display("[%0t] MISMATCH %s", $realtime, what);
		mismatches++;
	endtask

	// sample driver: offers queued samples, predicts each accepted one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				pixels_due.insert(pixels_due.size(), project_sample(sample_on_bus));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_on_bus = samples_to_send.pop_front();
					s_axis_tdata  <= IN_DATA_W'({sample_on_bus.range_mm,
						sample_on_bus.sample_index});
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor: random back-pressure, compares each word with the oldest
	always @(posedge clk) begin
		pixel_t want;
		logic [PIX_W-1:0] got_x, got_y;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				got_x = m_axis_tdata[PIX_W-1:0];
				got_y = m_axis_tdata[2*PIX_W-1:PIX_W];
				if (pixels_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word x=%0d y=%0d mark=%0b",
						got_x, got_y, m_axis_tuser));
				end else begin
					want = pixels_due.pop_front();
					if (got_x !== want.pixel_x)
						report_mismatch($sformatf("pixel_x got %0d want %0d",
							got_x, want.pixel_x));
					if (got_y !== want.pixel_y)
						report_mismatch($sformatf("pixel_y got %0d want %0d",
							got_y, want.pixel_y));
					if (m_axis_tuser !== want.mark)
						report_mismatch($sformatf("mark got %0b want %0b",
							m_axis_tuser, want.mark));
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		case (addr)
			REG_START_ANGLE: scan_cfg.start_angle = data;
			REG_ANGLE_STEP: scan_cfg.angle_step = data;
			REG_MIN_RANGE: scan_cfg.min_range_mm = data;
			REG_MAX_RANGE: scan_cfg.max_range_mm = data;
			REG_PIX_PER_M: scan_cfg.pixels_per_meter = data[PPM_W-1:0];
			default: ;
		endcase
	endtask

	// full register set; a stray write to the unused index goes first
	task automatic set_registers(input logic [15:0] start, input logic [15:0] step,
		input logic [15:0] min_r, input logic [15:0] max_r, input logic [15:0] ppm);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
		write_reg(REG_START_ANGLE, start);
		write_reg(REG_ANGLE_STEP, step);
		write_reg(REG_MIN_RANGE, min_r);
		write_reg(REG_MAX_RANGE, max_r);
		write_reg(REG_PIX_PER_M, ppm);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_sample(input int idx, input int range_mm);
		sample_t smp;
		smp.sample_index = IDX_W'(idx);
		smp.range_mm     = RANGE_W'(range_mm);
		samples_to_send.insert(samples_to_send.size(), smp);
	endtask

	// mostly ranges inside the window or near the image border, some noise
	task automatic queue_random(input int count);
		int     sel, idx;
		longint r;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			idx = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : (1 << IDX_W) - 1)
				: $urandom_range((1 << IDX_W) - 1);
			if (sel < 50) begin
				r = $urandom_range(scan_cfg.max_range_mm, scan_cfg.min_range_mm);
			end else if (sel < 75 && scan_cfg.pixels_per_meter != 0) begin
				r = longint'((IMG_SIDE / 2) * 1000 / scan_cfg.pixels_per_meter)
					+ longint'($urandom_range(60)) - 30;
			end else if (sel < 88) begin
				case ($urandom_range(3))
					0: r = longint'(scan_cfg.min_range_mm) - 1;
					1: r = scan_cfg.min_range_mm;
					2: r = scan_cfg.max_range_mm;
					default: r = longint'(scan_cfg.max_range_mm) + 1;
				endcase
			end else begin
				r = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535);
			end
			if (r < 0)
				r = 0;
			if (r > 65535)
				r = 65535;
			queue_sample(idx, int'(r));
		end
	endtask

	// sender holds back until every expected word is out, then the pipe settles
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || s_axis_tvalid || pixels_due.size() != 0);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	initial begin
		scan_cfg.start_angle      = RST_START_ANGLE;
		scan_cfg.angle_step       = RST_ANGLE_STEP;
		scan_cfg.min_range_mm     = RST_MIN_RANGE;
		scan_cfg.max_range_mm     = RST_MAX_RANGE;
		scan_cfg.pixels_per_meter = RST_PIX_PER_M;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: window edges, index extremes, non-finite reading
		queue_sample(0, 0);
		queue_sample(0, 119);
		queue_sample(0, 120);
		queue_sample(4095, 3500);
		queue_sample(4095, 3501);
		queue_sample(2048, 65535);
		queue_sample(1, 1000);
		queue_sample(90, 2500);
		queue_sample(270, 3000);
		queue_random(100);
		wait_until_drained();

		// a long stretch with both sides always ready
		send_idle_pct = 0;
		sink_idle_pct = 0;
		queue_random(100);
		wait_until_drained();
		send_idle_pct = IDLE_PCT;
		sink_idle_pct = IDLE_PCT;

		// beam at half turn, full window, top scale: negative fraction cases
		set_registers(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'd1000);
		queue_sample(0, 250);
		queue_sample(0, 251);
		queue_sample(0, 252);
		queue_sample(1, 65535);
		queue_sample(4095, 0);
		queue_sample(4095, 65535);
		queue_random(60);
		wait_until_drained();
		queue_random(60);
		wait_until_drained();

		// zero scale puts every accepted point at the center
		set_registers(16'h7FFF, 16'h8000, 16'd0, 16'hFFFF, 16'd0);
		queue_sample(0, 65535);
		queue_sample(3, 0);
		queue_random(80);
		wait_until_drained();

		// empty window drops everything
		set_registers(16'($urandom()), 16'd1, 16'd5000, 16'd4000, 16'd500);
		queue_sample(0, 4000);
		queue_sample(0, 4500);
		queue_sample(0, 5000);
		queue_random(40);
		wait_until_drained();

		// smallest nonzero scale, unit step
		set_registers(16'($urandom()), 16'd1, 16'd0, 16'hFFFF, 16'd1);
		queue_random(80);
		wait_until_drained();

		// upper scale bits set in the write word
		set_registers(16'($urandom()), 16'($urandom()), 16'd0, 16'd65534, 16'hFFFF);
		queue_random(80);
		wait_until_drained();

		repeat (3) begin
			set_registers(16'($urandom()), 16'($urandom()), 16'($urandom_range(2000)),
				16'($urandom_range(65535, 2000)), 16'($urandom()));
			queue_random(50);
			wait_until_drained();
		end

		repeat (PIPE_LAT * 2) @(posedge clk);
		if (mismatches == 0)
			$display("scan_polar_to_pixel test passed");
		else
			$display("scan_polar_to_pixel test failed");
		$finish;
	end

	// run limit
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("scan_polar_to_pixel test failed");
		$finish;
	end

endmodule
